// ----- design/assert_macros.svh -----
// Assertion macros for the RTL files of the tick converter; the queue uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed");

// The antecedent implies the consequent in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// The antecedent implies the consequent in the following cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- design/tt2ns_pkg.sv -----
// Package with constants and types of the tick to nanosecond converter.
`default_nettype none
package tt2ns_pkg;

  localparam int TIME_WIDTH_DEF = 64;
  localparam int MULT_W = 30;
  localparam int DIV_W = 32;
  localparam int FIFO_DEPTH = 4;

  localparam logic [MULT_W-1:0] NS_PER_SECOND = 30'd1000000000;
  localparam logic [MULT_W-1:0] RESET_MULT = 30'd125;
  localparam logic [DIV_W-1:0] RESET_DIV = 32'd3;
  localparam logic [MULT_W-1:0] ONE_MULT = 30'd1;

  // 1e9 holds the factors two and five nine times each.
  localparam logic [3:0] MAX_POW = 4'd9;

  // Inverse of five modulo 2^32; a product at or below the limit marks a multiple.
  localparam logic [31:0] INV5 = 32'hCCCC_CCCD;
  localparam logic [31:0] INV5_LIMIT = 32'h3333_3333;

  typedef struct packed {
    logic [MULT_W-1:0] mult;
    logic [DIV_W-1:0]  div;
  } ratio_t;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_TWOS  = 3'b010,
    S_FIVES = 3'b100
  } ratio_state_t;

endpackage
`default_nettype wire

// ----- design/tt2ns_ratio.sv -----
// Sequencer that reduces 1e9 over the counter frequency into multiplier and divisor.
`default_nettype none
module tt2ns_ratio (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [31:0]           cfg_data,
  output tt2ns_pkg::ratio_t          ratio,
  output logic                       busy
);

  tt2ns_pkg::ratio_state_t state;
  logic [tt2ns_pkg::MULT_W-1:0] mult;
  logic [tt2ns_pkg::DIV_W-1:0]  div;
  logic [3:0] cnt2;
  logic [3:0] cnt5;
  logic [31:0] div_q5;
  logic [tt2ns_pkg::MULT_W-1:0] mult_q5;

  // Exact division by five through the modular inverse.
  assign div_q5  = 32'(div * tt2ns_pkg::INV5);
  assign mult_q5 = tt2ns_pkg::MULT_W'(mult * tt2ns_pkg::INV5[tt2ns_pkg::MULT_W-1:0]);

  assign cfg_ready  = (state == tt2ns_pkg::S_IDLE);
  assign busy       = !cfg_ready;
  assign ratio.mult = mult;
  assign ratio.div  = div;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tt2ns_pkg::S_IDLE;
      mult  <= tt2ns_pkg::RESET_MULT;
      div   <= tt2ns_pkg::RESET_DIV;
      cnt2  <= 4'd0;
      cnt5  <= 4'd0;
    end else begin
      case (state)
        tt2ns_pkg::S_IDLE: begin
          if (cfg_valid) begin
            if (cfg_data == 32'd0) begin
              // The gcd with zero is 1e9 itself.
              mult <= tt2ns_pkg::ONE_MULT;
              div  <= 32'd0;
            end else begin
              mult  <= tt2ns_pkg::NS_PER_SECOND;
              div   <= cfg_data;
              cnt2  <= 4'd0;
              state <= tt2ns_pkg::S_TWOS;
            end
          end
        end
        tt2ns_pkg::S_TWOS: begin
          if (cnt2 != tt2ns_pkg::MAX_POW && !div[0]) begin
            div  <= div >> 1;
            mult <= mult >> 1;
            cnt2 <= cnt2 + 4'd1;
          end else begin
            cnt5  <= 4'd0;
            state <= tt2ns_pkg::S_FIVES;
          end
        end
        tt2ns_pkg::S_FIVES: begin
          if (cnt5 != tt2ns_pkg::MAX_POW && div_q5 <= tt2ns_pkg::INV5_LIMIT) begin
            div  <= div_q5;
            mult <= mult_q5;
            cnt5 <= cnt5 + 4'd1;
          end else begin
            state <= tt2ns_pkg::S_IDLE;
          end
        end
        default: state <= tt2ns_pkg::S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- design/tt2ns_front.sv -----
// Front end: accepts tick counts and forms the wrapped product in two stages.
`default_nettype none
module tt2ns_front #(
  parameter int TIME_WIDTH = tt2ns_pkg::TIME_WIDTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [63:0]           s_tdata,
  input  wire tt2ns_pkg::ratio_t     ratio,
  input  wire logic                  busy,
  input  wire logic                  fifo_full,
  output logic                       push,
  output logic [TIME_WIDTH-1:0]      product
);

  logic [63:0] tick_ext;
  logic        v1;
  logic        v2;
  logic [61:0] part_lo;
  logic [31:0] part_hi;
  logic [63:0] sum;
  logic        en;

  assign tick_ext = 64'(s_tdata[TIME_WIDTH-1:0]);
  assign en       = !v2 || !fifo_full;
  assign s_tready = en && !busy;
  assign push     = v2 && !fifo_full;
  assign sum      = 64'(part_lo) + {part_hi, 32'd0};

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (en) begin
      v1 <= s_tvalid && s_tready;
      v2 <= v1;
    end
  end

  // Two 32 by 30 partial products; only the low 32 bits of the upper one survive.
  always_ff @(posedge clk) begin
    if (en) begin
      part_lo <= 62'(tick_ext[31:0]) * 62'(ratio.mult);
      part_hi <= 32'(tick_ext[63:32]) * 32'(ratio.mult);
      product <= sum[TIME_WIDTH-1:0];
    end
  end

endmodule
`default_nettype wire

// ----- design/tt2ns_fifo.sv -----
// Short queue of products between the front end and the divider.
`default_nettype none
`include "assert_macros.svh"
module tt2ns_fifo #(
  parameter int WIDTH = tt2ns_pkg::TIME_WIDTH_DEF,
  parameter int DEPTH = tt2ns_pkg::FIFO_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rdata,
  output logic                  full,
  output logic                  nonempty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full     = (count == CW'(DEPTH));
  assign nonempty = (count != '0);
  assign rdata    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= wdata;
  end

  `ASSERT_ALWAYS(a_no_overflow, clk, rst, !(push && full))
  `ASSERT_IMPLIES(a_no_underflow, clk, rst, pop, nonempty)
  `ASSERT_NEXT(a_count_up, clk, rst, push && !pop, count == $past(count) + 1'b1)

endmodule
`default_nettype wire

// ----- design/tt2ns_div.sv -----
// Back end: restoring divider pipelined one quotient bit per stage; the last stage drives the output.
`default_nettype none
module tt2ns_div #(
  parameter int TIME_WIDTH = tt2ns_pkg::TIME_WIDTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire tt2ns_pkg::ratio_t     ratio,
  input  wire logic                  fifo_nonempty,
  input  wire logic [TIME_WIDTH-1:0] fifo_data,
  output logic                       pop,
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [63:0]                m_tdata
);

  localparam int DW = tt2ns_pkg::DIV_W;

  logic                  vld [TIME_WIDTH+1];
  logic [DW-1:0]         rem [TIME_WIDTH+1];
  logic [TIME_WIDTH-1:0] num [TIME_WIDTH+1];
  logic                  en;

  assign en       = !vld[TIME_WIDTH] || m_tready;
  assign pop      = en && fifo_nonempty;
  assign vld[0]   = fifo_nonempty;
  assign rem[0]   = '0;
  assign num[0]   = fifo_data;
  assign m_tvalid = vld[TIME_WIDTH];
  assign m_tdata  = 64'(num[TIME_WIDTH]);

  // A zero divisor makes every stage subtract, so the quotient comes out all ones.
  for (genvar i = 0; i < TIME_WIDTH; i++) begin : g_stage
    logic [DW:0] shifted;
    logic        ge;
    logic [DW:0] diff;

    assign shifted = {rem[i], num[i][TIME_WIDTH-1]};
    assign ge      = (shifted >= {1'b0, ratio.div});
    assign diff    = shifted - {1'b0, ratio.div};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[i+1] <= ge ? diff[DW-1:0] : shifted[DW-1:0];
        num[i+1] <= {num[i][TIME_WIDTH-2:0], ge};
      end
    end
  end

endmodule
`default_nettype wire

// ----- design/tick_to_nanosecond_converter.sv -----
// Top level of the tick to nanosecond converter.
//
//   channel  | direction | beat contents
//   ---------+-----------+---------------------------------------------
//   s_*      | in        | tdata[63:0] = tick_count
//   m_*      | out       | tdata[63:0] = nanoseconds
//   cfg_*    | in        | data[31:0]  = counter_frequency
//
// One tick count is taken per cycle unless the ratio sequencer is busy or the queue
// is full; a result passes the two multiply stages, the queue and one divider stage
// per bit. A frequency write keeps the block busy while the ratio sequencer strips
// factors of two and five, one factor per cycle.
// Reset loads the ratio for 24 MHz and empties the pipelines and the queue.
// An output stall freezes the divider; the queue lets the front run on until full.
`default_nettype none
module tick_to_nanosecond_converter #(
  parameter int TIME_WIDTH = tt2ns_pkg::TIME_WIDTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [63:0] s_tdata,   // [63:0] tick_count
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [63:0]      m_tdata,   // [63:0] nanoseconds
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [31:0] cfg_data
);

  tt2ns_pkg::ratio_t     ratio;
  logic                  busy;
  logic                  fifo_full;
  logic                  fifo_nonempty;
  logic                  push;
  logic                  pop;
  logic [TIME_WIDTH-1:0] product;
  logic [TIME_WIDTH-1:0] head;

  tt2ns_ratio u_ratio (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .ratio     (ratio),
    .busy      (busy)
  );

  tt2ns_front #(.TIME_WIDTH(TIME_WIDTH)) u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .ratio     (ratio),
    .busy      (busy),
    .fifo_full (fifo_full),
    .push      (push),
    .product   (product)
  );

  tt2ns_fifo #(.WIDTH(TIME_WIDTH), .DEPTH(tt2ns_pkg::FIFO_DEPTH)) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wdata    (product),
    .pop      (pop),
    .rdata    (head),
    .full     (fifo_full),
    .nonempty (fifo_nonempty)
  );

  tt2ns_div #(.TIME_WIDTH(TIME_WIDTH)) u_div (
    .clk           (clk),
    .rst           (rst),
    .ratio         (ratio),
    .fifo_nonempty (fifo_nonempty),
    .fifo_data     (head),
    .pop           (pop),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata)
  );

endmodule
`default_nettype wire

// ----- test/tb_top.sv -----
// Self-checking testbench of the tick to nanosecond converter.
`default_nettype none
module tb_top;
  localparam int TW = tt2ns_pkg::TIME_WIDTH_DEF;
  localparam int LATENCY = TW + 2;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int N_RANDOM = 1900;
  localparam logic [31:0] NS_SEC = 32'd1000000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [63:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [63:0] m_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [31:0] cfg_data = '0;

  logic [31:0] ratio_mult = 32'd125;
  logic [31:0] ratio_div = 32'd3;
  logic [63:0] ns_expected [$];
  int errors = 0;
  int idle_cycles = 0;
  bit hold_off = 1'b0;

  tick_to_nanosecond_converter u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic logic [31:0] gcd32(logic [31:0] x, logic [31:0] y);
    logic [31:0] r;
    while (y != 0) begin
      r = x % y;
      x = y;
      y = r;
    end
    return x;
  endfunction

  function automatic logic [63:0] ticks_to_ns(logic [63:0] ticks);
    logic [63:0] product;
    product = ticks * {32'd0, ratio_mult};
    if (ratio_div == 0) return '1;
    return product / {32'd0, ratio_div};
  endfunction

  task automatic write_frequency(logic [31:0] freq);
    logic [31:0] g;
    while (ns_expected.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= freq;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    g = gcd32(NS_SEC, freq);
    ratio_mult = NS_SEC / g;
    ratio_div = freq / g;
    // Gives the ratio sequencer time to finish before ticks may follow.
    repeat (24) @(posedge clk);
  endtask

  // Offers one beat, with a random gap first when gaps are wanted.
  task automatic send_ticks(logic [63:0] ticks, bit gaps);
    if (gaps && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= ticks;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    ns_expected.push_back(ticks_to_ns(ticks));
  endtask

  task automatic send_burst(logic [63:0] ticks);
    send_ticks(ticks, 1'b1);
  endtask

  function automatic logic [63:0] rand_ticks();
    case ($urandom_range(0, 5))
      0: return {32'd0, $urandom()};
      1: return '1 - $urandom_range(0, 3);
      2: return {$urandom(), $urandom()} >> $urandom_range(0, 63);
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  // Receiver: random stall pattern, plus one long hold-off.
  initial begin
    int hold;
    forever begin
      @(posedge clk);
      if (hold_off) begin
        m_tready <= 1'b0;
        for (hold = 0; hold < 300; hold++) @(posedge clk);
        hold_off = 1'b0;
      end
      case ($urandom_range(0, 3))
        0: m_tready <= 1'b1;
        1: m_tready <= ($urandom_range(0, 3) != 0);
        2: m_tready <= ($urandom_range(0, 1) != 0);
        default: m_tready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (ns_expected.size() == 0) begin
        $display("%0t: unexpected beat, actual %h", $time, m_tdata);
        errors++;
      end else begin
        if (m_tdata !== ns_expected[0]) begin
          $display("%0t: nanoseconds expected %h actual %h", $time, ns_expected[0], m_tdata);
          errors++;
        end
        void'(ns_expected.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  typedef struct {
    logic [63:0] ticks;
    bit          known;
    logic [63:0] ns;
  } ticks_row_t;

  ticks_row_t directed [] = '{
    '{64'd0, 1'b1, 64'd0},
    '{64'd3, 1'b1, 64'd125},
    '{64'd24000000, 1'b1, 64'd1000000000},
    '{64'd1, 1'b1, 64'd41},
    '{64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 64'd0},
    '{64'h8000_0000_0000_0000, 1'b0, 64'd0},
    '{64'h0000_0000_FFFF_FFFF, 1'b0, 64'd0},
    '{64'h5555_5555_5555_5555, 1'b0, 64'd0},
    '{64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 64'd0}
  };

  logic [31:0] freqs [] = '{32'd1, 32'hFFFF_FFFF, 32'd0, 32'd1000000000,
                            32'd19200000, 32'd1024, 32'd7, 32'd3125};

  initial begin
    int f;
    int k;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    repeat (LATENCY) @(posedge clk);
    foreach (directed[i]) begin
      send_ticks(directed[i].ticks, 1'b0);
      if (directed[i].known && ns_expected[$] !== directed[i].ns) begin
        $display("%0t: table row %0d expected %h predicted %h", $time, i,
                 directed[i].ns, ns_expected[$]);
        errors++;
      end
    end
    // Back-to-back beats while the receiver holds off, so the input stalls.
    hold_off = 1'b1;
    for (k = 0; k < 80; k++) send_ticks(rand_ticks(), 1'b0);
    s_tvalid <= 1'b0;
    // Zero frequency makes the divisor zero.
    write_frequency(32'd0);
    send_ticks(64'd5, 1'b0);
    send_ticks('1, 1'b0);
    s_tvalid <= 1'b0;
    for (f = 0; f < freqs.size(); f++) begin
      if (f != 0) write_frequency(freqs[f]);
      else write_frequency(freqs[0]);
      for (k = 0; k < N_RANDOM / (freqs.size() + 2); k++) send_burst(rand_ticks());
      s_tvalid <= 1'b0;
    end
    for (f = 0; f < 2; f++) begin
      write_frequency($urandom());
      for (k = 0; k < N_RANDOM / (freqs.size() + 2); k++) send_burst(rand_ticks());
      s_tvalid <= 1'b0;
    end
    while (ns_expected.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end
endmodule
`default_nettype wire

// ----- tick_to_nanosecond_converter.f -----
+incdir+design
design/tt2ns_pkg.sv
design/tt2ns_ratio.sv
design/tt2ns_front.sv
design/tt2ns_fifo.sv
design/tt2ns_div.sv
design/tick_to_nanosecond_converter.sv
test/tb_top.sv
